// ===== hdl/vpts_pkg.sv =====
// Shared types and constants for the vertex projection block.
`timescale 1ns / 1ps
`default_nettype none
package vpts_pkg;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int SIZE_W = 13;
  localparam int IDX_W = 4;
  localparam logic [SIZE_W-1:0] WIDTH_RESET = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic {OP_LOAD = 1'b0, OP_VERTEX = 1'b1} op_t;
  typedef enum logic [0:0] {REG_WIDTH = 1'b0, REG_HEIGHT = 1'b1} reg_idx_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_MAC, BK_DIV, BK_SCALE, BK_SCREEN, BK_OUT
  } back_state_t;
endpackage
`default_nettype wire

// ===== hdl/vpts_front.sv =====
// Front end: accepts items, stores matrix loads, queues vertices for the back end.
`timescale 1ns / 1ps
`default_nettype none
module vpts_front #(
  parameter int VALUE_WIDTH = vpts_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  output logic in_full,
  input  wire logic in_operation,
  input  wire logic [vpts_pkg::IDX_W-1:0] in_element_index,
  input  wire logic signed [VALUE_WIDTH-1:0] in_element_value,
  input  wire logic signed [VALUE_WIDTH-1:0] in_vertex_x,
  input  wire logic signed [VALUE_WIDTH-1:0] in_vertex_y,
  input  wire logic signed [VALUE_WIDTH-1:0] in_vertex_z,
  input  wire logic back_busy,
  input  wire logic q_take,
  output logic q_valid,
  output logic signed [VALUE_WIDTH-1:0] q_x,
  output logic signed [VALUE_WIDTH-1:0] q_y,
  output logic signed [VALUE_WIDTH-1:0] q_z,
  input  wire logic [vpts_pkg::IDX_W-1:0] m_addr,
  output logic signed [VALUE_WIDTH-1:0] m_data
);
  logic signed [VALUE_WIDTH-1:0] mem [16];
  logic accept;
  // One-entry vertex queue; loads stall while any vertex is in flight so
  // a later load never alters the matrix under an earlier vertex.
  assign in_full = q_valid || (back_busy && (in_operation == vpts_pkg::OP_LOAD));
  assign accept = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (accept && in_operation == vpts_pkg::OP_LOAD) begin
      mem[in_element_index] <= in_element_value;
    end
    m_data <= mem[m_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid <= 1'b0;
    end else if (accept && in_operation == vpts_pkg::OP_VERTEX) begin
      q_valid <= 1'b1;
    end else if (q_take) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_operation == vpts_pkg::OP_VERTEX) begin
      q_x <= in_vertex_x;
      q_y <= in_vertex_y;
      q_z <= in_vertex_z;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/vpts_back.sv =====
// Back end: dot products, reciprocal, scaling and viewport mapping, one vertex at a time.
`timescale 1ns / 1ps
`default_nettype none
module vpts_back #(
  parameter int FRACTION_BITS = vpts_pkg::FRACTION_BITS_DEF,
  parameter int VALUE_WIDTH = vpts_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  output logic q_take,
  input  wire logic signed [VALUE_WIDTH-1:0] q_x,
  input  wire logic signed [VALUE_WIDTH-1:0] q_y,
  input  wire logic signed [VALUE_WIDTH-1:0] q_z,
  output logic [vpts_pkg::IDX_W-1:0] m_addr,
  input  wire logic signed [VALUE_WIDTH-1:0] m_data,
  input  wire logic [vpts_pkg::SIZE_W-1:0] width,
  input  wire logic [vpts_pkg::SIZE_W-1:0] height,
  output logic busy,
  output logic out_empty,
  input  wire logic out_pop,
  output logic signed [VALUE_WIDTH-1:0] out_screen_x,
  output logic signed [VALUE_WIDTH-1:0] out_screen_y,
  output logic out_divide_fault
);
  localparam int VW = VALUE_WIDTH;
  localparam int PW = 2 * VW;
  localparam int AW = VW + 3;
  localparam int NW = 2 * FRACTION_BITS + 1;
  localparam int DW = (NW > VW) ? NW : VW;
  localparam int CW = 6;
  localparam int MAC_LAST = 16;
  localparam int SW = VW + vpts_pkg::SIZE_W + 2;
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  function automatic logic signed [VW-1:0] sat_a(input logic signed [AW-1:0] v);
    if (v > $signed({{(AW-VW){1'b0}}, VMAX})) return VMAX;
    if (v < $signed({{(AW-VW){1'b1}}, VMIN})) return VMIN;
    return v[VW-1:0];
  endfunction
  function automatic logic signed [VW-1:0] sat_p(input logic signed [PW:0] v);
    if (v > $signed({{(PW+1-VW){1'b0}}, VMAX})) return VMAX;
    if (v < $signed({{(PW+1-VW){1'b1}}, VMIN})) return VMIN;
    return v[VW-1:0];
  endfunction
  function automatic logic signed [VW-1:0] sat_s(input logic signed [SW-1:0] v);
    if (v > $signed({{(SW-VW){1'b0}}, VMAX})) return VMAX;
    if (v < $signed({{(SW-VW){1'b1}}, VMIN})) return VMIN;
    return v[VW-1:0];
  endfunction

  vpts_pkg::back_state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic signed [AW-1:0] acc_r [3];
  logic signed [VW-1:0] xp_r, yp_r, w_r, r_r;
  logic signed [VW-1:0] x_r, y_r, z_r;
  logic signed [VW-1:0] sx_r, sy_r;
  logic fault_r;
  logic [DW-1:0] rem_r, quo_r, mag_w;
  logic neg_w;
  logic out_valid_r;
  logic out_load;

  // MAC step cnt: read all 16 entries in order, data in the next cycle;
  // column 2 belongs to z' and is read and skipped.
  logic [1:0] pcol, prow, acc_sel;
  logic [CW-1:0] pcnt;
  logic signed [VW-1:0] vsel;
  logic signed [PW-1:0] prod;
  logic signed [VW-1:0] term;

  always_comb begin
    m_addr = cnt_r[vpts_pkg::IDX_W-1:0];
    pcnt = cnt_r - CW'(1);
    pcol = pcnt[1:0];
    prow = pcnt[3:2];
    acc_sel = (pcol == 2'd3) ? 2'd2 : pcol;
    case (prow)
      2'd0: vsel = x_r;
      2'd1: vsel = y_r;
      default: vsel = z_r;
    endcase
    prod = m_data * vsel;
    term = (prow == 2'd3) ? m_data
         : sat_p($signed({prod[PW-1], prod}) >>> FRACTION_BITS);
  end

  // Unsigned magnitude of w for restoring division of 2^(2F).
  assign neg_w = w_r[VW-1];
  always_comb begin
    logic [VW-1:0] m;
    m = neg_w ? (~w_r + VW'(1)) : w_r;
    mag_w = DW'(m);
  end

  logic [DW:0] trial;
  assign trial = {rem_r, quo_r[DW-1]} - {1'b0, mag_w};

  // Scaling multiplies and screen mapping.
  logic signed [PW-1:0] sprod;
  logic signed [VW-1:0] sopnd;
  assign sopnd = cnt_r[0] ? yp_r : xp_r;
  assign sprod = sopnd * r_r;
  logic signed [VW:0] sv;
  logic [vpts_pkg::SIZE_W-1:0] ssz;
  logic signed [SW-1:0] smap;
  assign sv = cnt_r[0] ? -{yp_r[VW-1], yp_r} : {xp_r[VW-1], xp_r};
  assign ssz = cnt_r[0] ? height : width;
  assign smap = SW'(sv) * $signed({1'b0, ssz})
              + $signed(SW'({1'b0, ssz}) <<< (FRACTION_BITS - 1));

  logic signed [VW-1:0] rq;
  always_comb begin
    logic [DW:0] q;
    q = {1'b0, quo_r};
    if (q > (DW+1)'(VMAX)) rq = neg_w ? VMIN : VMAX;
    else rq = neg_w ? -VW'(q) : VW'(q);
  end

  // Hand the finished point to the output register once it is free.
  assign out_load = (st_r == vpts_pkg::BK_OUT) && (!out_valid_r || out_pop);

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    q_take = 1'b0;
    case (st_r)
      vpts_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          st_nxt = vpts_pkg::BK_MAC;
          cnt_nxt = '0;
        end
      end
      vpts_pkg::BK_MAC: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(MAC_LAST)) begin
          st_nxt = vpts_pkg::BK_DIV;
          cnt_nxt = '0;
        end
      end
      vpts_pkg::BK_DIV: begin
        if (w_r == '0) begin
          st_nxt = vpts_pkg::BK_OUT;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
          if (cnt_r == CW'(DW)) begin
            st_nxt = vpts_pkg::BK_SCALE;
            cnt_nxt = '0;
          end
        end
      end
      vpts_pkg::BK_SCALE: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(1)) begin
          st_nxt = vpts_pkg::BK_SCREEN;
          cnt_nxt = '0;
        end
      end
      vpts_pkg::BK_SCREEN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(1)) st_nxt = vpts_pkg::BK_OUT;
      end
      vpts_pkg::BK_OUT: begin
        if (out_load) st_nxt = vpts_pkg::BK_IDLE;
      end
      default: st_nxt = vpts_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= vpts_pkg::BK_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      vpts_pkg::BK_IDLE: begin
        x_r <= q_x; y_r <= q_y; z_r <= q_z;
        for (int i = 0; i < 3; i++) acc_r[i] <= '0;
      end
      vpts_pkg::BK_MAC: begin
        if (cnt_r != '0 && pcol != 2'd2) begin
          acc_r[acc_sel] <= acc_r[acc_sel] + AW'(term);
        end
        if (cnt_r == CW'(MAC_LAST)) begin
          xp_r <= sat_a(acc_r[0]);
          yp_r <= sat_a(acc_r[1]);
          w_r <= sat_a(acc_r[2] + AW'(term));
        end
        rem_r <= '0;
        quo_r <= {{(DW-1){1'b0}}, 1'b1} << (2 * FRACTION_BITS);
      end
      vpts_pkg::BK_DIV: begin
        if (w_r == '0) begin
          sx_r <= '0;
          sy_r <= '0;
          fault_r <= 1'b1;
        end else if (cnt_r < CW'(DW)) begin
          if (!trial[DW]) begin
            rem_r <= trial[DW-1:0];
            quo_r <= {quo_r[DW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[DW-2:0], quo_r[DW-1]};
            quo_r <= {quo_r[DW-2:0], 1'b0};
          end
        end else begin
          r_r <= rq;
        end
      end
      vpts_pkg::BK_SCALE: begin
        if (cnt_r[0]) yp_r <= sat_p($signed({sprod[PW-1], sprod}) >>> FRACTION_BITS);
        else xp_r <= sat_p($signed({sprod[PW-1], sprod}) >>> FRACTION_BITS);
      end
      vpts_pkg::BK_SCREEN: begin
        if (cnt_r[0]) sy_r <= sat_s(smap);
        else sx_r <= sat_s(smap);
        fault_r <= 1'b0;
      end
      vpts_pkg::BK_OUT: begin
        if (out_load) begin
          out_screen_x <= sx_r;
          out_screen_y <= sy_r;
          out_divide_fault <= fault_r;
        end
      end
      default: ;
    endcase
  end

  assign busy = (st_r != vpts_pkg::BK_IDLE) || q_valid;
  assign out_empty = !out_valid_r;

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> st_r == vpts_pkg::BK_IDLE && q_valid) else $error("take while busy");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pop |=> out_valid_r && $stable(out_screen_x)
      && $stable(out_screen_y) && $stable(out_divide_fault))
    else $error("waiting result changed");
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_divide_fault |-> out_screen_x == '0 && out_screen_y == '0)
    else $error("fault with nonzero point");
endmodule
`default_nettype wire

// ===== hdl/vertex_project_to_screen_core.sv =====
// Top level of the vertex projection block: config registers, front end, back end.
`timescale 1ns / 1ps
`default_nettype none
// Push items into the block like a queue. A load item (operation 0) writes one
// matrix element; a vertex item (operation 1) is parked in a one-entry queue and
// carried out by the back end. Values are signed fixed point, Q16.16 with the
// default parameters. Once the back end takes a vertex, it runs a serial
// multiply-accumulate that sweeps all 16 matrix entries through the store read
// port, a restoring divider for 1/w, scaling of x and y, viewport mapping of x
// and y, and a hand-off of the point to the output register. The back end takes
// the next queued vertex only when it is back in idle, so it works on one vertex
// at a time while one more vertex can wait in the queue. A zero w skips the
// division, scaling and mapping and gives a zero point with divide_fault set. A
// finished point waits in the back end while the output register still holds an
// unpopped result. A load waits while a vertex is in flight. Results come out
// through a queue-style port (empty/pop). Write screen size registers only while
// idle.
module vertex_project_to_screen_core #(
  parameter int FRACTION_BITS = vpts_pkg::FRACTION_BITS_DEF,
  parameter int VALUE_WIDTH = vpts_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  output logic full,
  input  wire logic in_operation,
  input  wire logic [vpts_pkg::IDX_W-1:0] in_element_index,
  input  wire logic signed [VALUE_WIDTH-1:0] in_element_value,
  input  wire logic signed [VALUE_WIDTH-1:0] in_vertex_x,
  input  wire logic signed [VALUE_WIDTH-1:0] in_vertex_y,
  input  wire logic signed [VALUE_WIDTH-1:0] in_vertex_z,
  output logic empty,
  input  wire logic pop,
  output logic signed [VALUE_WIDTH-1:0] out_screen_x,
  output logic signed [VALUE_WIDTH-1:0] out_screen_y,
  output logic out_divide_fault,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic cfg_index,
  input  wire logic [vpts_pkg::SIZE_W-1:0] cfg_data
);
  logic [vpts_pkg::SIZE_W-1:0] width_r, height_r;
  logic busy, q_valid, q_take;
  logic signed [VALUE_WIDTH-1:0] q_x, q_y, q_z, m_data;
  logic [vpts_pkg::IDX_W-1:0] m_addr;

  // Always take config writes; hold each size register otherwise.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= vpts_pkg::WIDTH_RESET;
      height_r <= vpts_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == vpts_pkg::REG_WIDTH) width_r <= cfg_data;
      else height_r <= cfg_data;
    end
  end

  vpts_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk, .rst_n, .in_push(push), .in_full(full), .in_operation, .in_element_index,
    .in_element_value, .in_vertex_x, .in_vertex_y, .in_vertex_z,
    .back_busy(busy), .q_take, .q_valid, .q_x, .q_y, .q_z, .m_addr, .m_data
  );

  vpts_back #(.FRACTION_BITS(FRACTION_BITS), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_x, .q_y, .q_z, .m_addr, .m_data,
    .width(width_r), .height(height_r), .busy, .out_empty(empty), .out_pop(pop),
    .out_screen_x, .out_screen_y, .out_divide_fault
  );
endmodule
`default_nettype wire
